@@ rtl/core/tswt_pkg.sv @@
`default_nettype none
package tswt_pkg;

   // class codes
   localparam logic [1:0] CLS_LOW  = 2'd0;
   localparam logic [1:0] CLS_MID  = 2'd1;
   localparam logic [1:0] CLS_HIGH = 2'd2;

   localparam int TIME_W      = 32;
   localparam int CLASS_W     = 2;
   localparam int HIGH_LIM_W  = 4;
   localparam int LIMIT_W     = 6;
   localparam int WINDOW_W    = 17;
   localparam int CSR_DATA_W  = 17;
   localparam int CSR_IDX_W   = 3;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HIGH_LIMIT_NORMAL = 3'd0,
      CSR_HIGH_LIMIT_CRISIS = 3'd1,
      CSR_MID_LIMIT_NORMAL  = 3'd2,
      CSR_MID_LIMIT_CRISIS  = 3'd3,
      CSR_HIGH_WINDOW       = 3'd4,
      CSR_MID_WINDOW        = 3'd5
   } csr_reg_type;

   localparam logic [HIGH_LIM_W-1:0] RST_HIGH_LIMIT_NORMAL = 4'd3;
   localparam logic [HIGH_LIM_W-1:0] RST_HIGH_LIMIT_CRISIS = 4'd6;
   localparam logic [LIMIT_W-1:0]    RST_MID_LIMIT_NORMAL  = 6'd10;
   localparam logic [LIMIT_W-1:0]    RST_MID_LIMIT_CRISIS  = 6'd20;
   localparam logic [WINDOW_W-1:0]   RST_HIGH_WINDOW       = 17'd1800;
   localparam logic [WINDOW_W-1:0]   RST_MID_WINDOW        = 17'd3600;

   typedef struct packed {
      logic [TIME_W-1:0]  now_seconds;
      logic [CLASS_W-1:0] request_class;
      logic               crisis;
   } req_payload_type;

   typedef struct packed {
      logic [CLASS_W-1:0] granted_class;
      logic               demoted;
   } rsp_payload_type;

   // sequencer to log
   typedef struct packed {
      logic                start;
      logic [TIME_W-1:0]   now;
      logic [LIMIT_W-1:0]  limit;
      logic [WINDOW_W-1:0] window;
   } log_ctrl_type;

   // log to sequencer
   typedef struct packed {
      logic busy;
      logic done;
      logic granted;
   } log_stat_type;

endpackage
`default_nettype wire

@@ rtl/core/tswt_chan_if.sv @@
`default_nettype none
interface tswt_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/tswt_log.sv @@
`default_nettype none
module tswt_log #(
   parameter int SLOTS = 8
) (
   input  wire                    clock,
   input  wire                    reset,
   input  tswt_pkg::log_ctrl_type ctrl,
   output tswt_pkg::log_stat_type stat
);
   import tswt_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

   typedef enum logic [2:0] {
      LS_IDLE   = 3'b001,
      LS_SCAN   = 3'b010,
      LS_DECIDE = 3'b100
   } log_state_type;

   logic [TIME_W-1:0] mem [SLOTS];

   log_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]  chk_idx_ff, chk_idx_in;
   logic [TIME_W-1:0] rd_data_ff;
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic [CNT_W-1:0]  live_ff, live_in;
   logic              free_found_ff, free_found_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic              done_ff, done_in;
   logic              granted_ff, granted_in;

   logic              rd_en;
   logic              mem_we;
   logic [TIME_W-1:0] age;
   logic              entry_live;
   logic              grant;

   assign age        = ctrl.now - rd_data_ff;
   assign entry_live = valid_ff[chk_idx_ff] && !(age > TIME_W'(ctrl.window));
   assign grant      = (CMP_W'(live_ff) < CMP_W'(ctrl.limit)) && free_found_ff;

   always_comb begin
      state_in      = state_ff;
      issue_in      = issue_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      valid_in      = valid_ff;
      live_in       = live_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      done_in       = 1'b0;
      granted_in    = 1'b0;
      rd_en         = 1'b0;
      mem_we        = 1'b0;
      case (state_ff)
         LS_IDLE: begin
            if (ctrl.start) begin
               state_in      = LS_SCAN;
               issue_in      = '0;
               live_in       = '0;
               free_found_in = 1'b0;
               free_idx_in   = '0;
            end
         end
         LS_SCAN: begin
            // read slot issue_ff, check the slot read last cycle
            if (issue_ff != SLOTS_CNT) begin
               rd_en      = 1'b1;
               issue_in   = issue_ff + 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = issue_ff[IDX_W-1:0];
            end
            if (chk_vld_ff) begin
               if (entry_live) begin
                  live_in = live_ff + 1'b1;
               end else begin
                  valid_in[chk_idx_ff] = 1'b0;
                  if (!free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = chk_idx_ff;
                  end
               end
            end
            if (issue_ff == SLOTS_CNT && !chk_vld_ff) begin
               state_in = LS_DECIDE;
            end
         end
         LS_DECIDE: begin
            if (grant) begin
               mem_we                = 1'b1;
               valid_in[free_idx_ff] = 1'b1;
            end
            done_in    = 1'b1;
            granted_in = grant;
            state_in   = LS_IDLE;
         end
         default: begin
            state_in = LS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= LS_IDLE;
         issue_ff      <= '0;
         chk_vld_ff    <= 1'b0;
         valid_ff      <= '0;
         live_ff       <= '0;
         free_found_ff <= 1'b0;
         done_ff       <= 1'b0;
         granted_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_ff      <= issue_in;
         chk_vld_ff    <= chk_vld_in;
         valid_ff      <= valid_in;
         live_ff       <= live_in;
         free_found_ff <= free_found_in;
         done_ff       <= done_in;
         granted_ff    <= granted_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff  <= chk_idx_in;
      free_idx_ff <= free_idx_in;
   end

   // grant-time store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[free_idx_ff] <= ctrl.now;
      end
      if (rd_en) begin
         rd_data_ff <= mem[issue_ff[IDX_W-1:0]];
      end
   end

   assign stat.busy    = (state_ff != LS_IDLE);
   assign stat.done    = done_ff;
   assign stat.granted = granted_ff;

endmodule
`default_nettype wire

@@ rtl/core/tiered_sliding_window_throttle.sv @@
// Path, request beat to result beat: a low class request goes straight to the result, a
//   middle one scans the middle log, a high one scans the high log and, if throttled
//   there, the middle log as well, to fall to middle or low.
// Throughput: one request at a time, the next taken at the earliest on the edge the result
//   beat goes out; a held result stalls the next one in ST_DONE. One slot read per cycle.
// Reset (synchronous): logs emptied at once by per-slot valid flops, registers to defaults.
`default_nettype none
module tiered_sliding_window_throttle #(
   parameter int HIGH_SLOTS = 8,
   parameter int MID_SLOTS  = 32
) (
   input  wire                                  clock,
   input  wire                                  reset,
   tswt_chan_if.sink                            req_chan,
   tswt_chan_if.source                          rsp_chan,
   input  wire                                  csr_we,
   input  wire [tswt_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire [tswt_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import tswt_pkg::*;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_HIGH = 4'b0010,
      ST_MID  = 4'b0100,
      ST_DONE = 4'b1000
   } top_state_type;

   // configuration registers
   logic [HIGH_LIM_W-1:0] high_lim_norm_ff, high_lim_norm_in;
   logic [HIGH_LIM_W-1:0] high_lim_cris_ff, high_lim_cris_in;
   logic [LIMIT_W-1:0]    mid_lim_norm_ff, mid_lim_norm_in;
   logic [LIMIT_W-1:0]    mid_lim_cris_ff, mid_lim_cris_in;
   logic [WINDOW_W-1:0]   high_window_ff, high_window_in;
   logic [WINDOW_W-1:0]   mid_window_ff, mid_window_in;

   top_state_type         state_ff, state_in;
   req_payload_type       req_ff, req_in;
   logic                  hstart_ff, hstart_in;
   logic                  mstart_ff, mstart_in;
   logic [CLASS_W-1:0]    res_class_ff, res_class_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_payload_type       rsp_data_ff, rsp_data_in;

   log_ctrl_type          hctrl, mctrl;
   log_stat_type          hstat, mstat;

   logic                  req_beat;
   logic                  req_logged;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_beat       = req_chan.valid && req_chan.ready;
   // only middle and high requests can be demoted; code 3 counts as low
   assign req_logged     = (req_ff.request_class == CLS_HIGH) ||
                           (req_ff.request_class == CLS_MID);

   always_comb begin
      high_lim_norm_in = high_lim_norm_ff;
      high_lim_cris_in = high_lim_cris_ff;
      mid_lim_norm_in  = mid_lim_norm_ff;
      mid_lim_cris_in  = mid_lim_cris_ff;
      high_window_in   = high_window_ff;
      mid_window_in    = mid_window_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HIGH_LIMIT_NORMAL: high_lim_norm_in = csr_wdata[HIGH_LIM_W-1:0];
            CSR_HIGH_LIMIT_CRISIS: high_lim_cris_in = csr_wdata[HIGH_LIM_W-1:0];
            CSR_MID_LIMIT_NORMAL:  mid_lim_norm_in  = csr_wdata[LIMIT_W-1:0];
            CSR_MID_LIMIT_CRISIS:  mid_lim_cris_in  = csr_wdata[LIMIT_W-1:0];
            CSR_HIGH_WINDOW:       high_window_in   = csr_wdata[WINDOW_W-1:0];
            CSR_MID_WINDOW:        mid_window_in    = csr_wdata[WINDOW_W-1:0];
            default: begin
               // unmapped index: write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_lim_norm_ff <= RST_HIGH_LIMIT_NORMAL;
         high_lim_cris_ff <= RST_HIGH_LIMIT_CRISIS;
         mid_lim_norm_ff  <= RST_MID_LIMIT_NORMAL;
         mid_lim_cris_ff  <= RST_MID_LIMIT_CRISIS;
         high_window_ff   <= RST_HIGH_WINDOW;
         mid_window_ff    <= RST_MID_WINDOW;
      end else begin
         high_lim_norm_ff <= high_lim_norm_in;
         high_lim_cris_ff <= high_lim_cris_in;
         mid_lim_norm_ff  <= mid_lim_norm_in;
         mid_lim_cris_ff  <= mid_lim_cris_in;
         high_window_ff   <= high_window_in;
         mid_window_ff    <= mid_window_in;
      end
   end

   // log controls; the request register holds still for the whole scan
   assign hctrl.start  = hstart_ff;
   assign hctrl.now    = req_ff.now_seconds;
   assign hctrl.limit  = req_ff.crisis ? LIMIT_W'(high_lim_cris_ff)
                                       : LIMIT_W'(high_lim_norm_ff);
   assign hctrl.window = high_window_ff;

   assign mctrl.start  = mstart_ff;
   assign mctrl.now    = req_ff.now_seconds;
   assign mctrl.limit  = req_ff.crisis ? mid_lim_cris_ff : mid_lim_norm_ff;
   assign mctrl.window = mid_window_ff;

   // sequencer: high log, middle log on a throttle or for a middle request, then result
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      hstart_in    = 1'b0;
      mstart_in    = 1'b0;
      res_class_in = res_class_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               req_in = req_chan.data;
               case (req_chan.data.request_class)
                  CLS_HIGH: begin
                     hstart_in = 1'b1;
                     state_in  = ST_HIGH;
                  end
                  CLS_MID: begin
                     mstart_in = 1'b1;
                     state_in  = ST_MID;
                  end
                  default: begin
                     res_class_in = CLS_LOW;
                     state_in     = ST_DONE;
                  end
               endcase
            end
         end
         ST_HIGH: begin
            if (hstat.done) begin
               if (hstat.granted) begin
                  res_class_in = CLS_HIGH;
                  state_in     = ST_DONE;
               end else begin
                  mstart_in = 1'b1;
                  state_in  = ST_MID;
               end
            end
         end
         ST_MID: begin
            if (mstat.done) begin
               res_class_in = mstat.granted ? CLS_MID : CLS_LOW;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.granted_class = res_class_ff;
               rsp_data_in.demoted       = req_logged &&
                                           (res_class_ff < req_ff.request_class);
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hstart_ff    <= 1'b0;
         mstart_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hstart_ff    <= hstart_in;
         mstart_ff    <= mstart_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      res_class_ff <= res_class_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   tswt_log #(
      .SLOTS (HIGH_SLOTS)
   ) u_high_log (
      .clock (clock),
      .reset (reset),
      .ctrl  (hctrl),
      .stat  (hstat)
   );

   tswt_log #(
      .SLOTS (MID_SLOTS)
   ) u_mid_log (
      .clock (clock),
      .reset (reset),
      .ctrl  (mctrl),
      .stat  (mstat)
   );

   // the two logs are never scanned together
   a_logs_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(hstat.busy && mstat.busy))
      else $error("high and middle logs busy together");

   // a scan is only started on an idle log
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      (hstart_ff || mstart_ff) |-> (!hstat.busy && !mstat.busy))
      else $error("log started while a scan is running");

   // a high grant is never reported as a demotion
   a_high_not_demoted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.demoted && rsp_data_ff.granted_class == CLS_HIGH))
      else $error("high grant flagged as demoted");

   // middle log only scanned after a high throttle or for a middle request
   a_mid_start_cause: assert property (@(posedge clock) disable iff (reset)
      mstart_ff |-> (req_ff.request_class == CLS_MID ||
                     (req_ff.request_class == CLS_HIGH && !$past(hstat.granted))))
      else $error("middle log started without cause");

endmodule
`default_nettype wire
